// File: hdl/swsk_pkg.sv
// ----------------------------------------------------------------------------
// swsk_pkg
// Shared constants, codes and controller/datapath types for the six-wheel
// steering kinematics block.
// ----------------------------------------------------------------------------
package swsk_pkg;

	// field widths
	localparam int unsigned CMD_W   = 16;
	localparam int unsigned SPEED_W = 21;
	localparam int unsigned ANGLE_W = 15;

	// rover geometry, meters in Q0.16
	localparam logic [14:0] GEO_D1 = 15'd11600;
	localparam logic [14:0] GEO_D2 = 15'd20316;
	localparam logic [14:0] GEO_D3 = 15'd17957;
	localparam logic [14:0] GEO_D4 = 15'd16581;

	// pi/2 in Q.16
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

	// drive modes
	localparam logic [1:0] MODE_STOP     = 2'd0;
	localparam logic [1:0] MODE_STRAIGHT = 2'd1;
	localparam logic [1:0] MODE_ROTATE   = 2'd2;
	localparam logic [1:0] MODE_ARC      = 2'd3;

	// operand selects for the hypot and atan2 jobs
	localparam logic [1:0] SEL_ROT13    = 2'd0;
	localparam logic [1:0] SEL_ROT12    = 2'd1;
	localparam logic [1:0] SEL_ARC_NEAR = 2'd2;
	localparam logic [1:0] SEL_ARC_FAR  = 2'd3;

	// index of the last wheel speed
	localparam logic [2:0] LAST_WHEEL = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       prep;
		logic       sq_first;
		logic       sq_second;
		logic       sqrt_start;
		logic       sqrt_store;
		logic       cor_start;
		logic       cor_store;
		logic       assign_out;
		logic       conv_first;
		logic       conv_second;
		logic       out_load;
		logic [1:0] sel;
		logic [2:0] idx;
	} swsk_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       repeated;
		logic [1:0] mode;
		logic       sqrt_done;
		logic       cor_done;
		logic       out_free;
	} swsk_status_t;

	// cordic arctangent steps, Q.16
	function automatic logic [15:0] atan_entry(input logic [3:0] idx);
		logic [15:0] r;
		case (idx)
			4'd0:    r = 16'd51472;
			4'd1:    r = 16'd30386;
			4'd2:    r = 16'd16055;
			4'd3:    r = 16'd8150;
			4'd4:    r = 16'd4091;
			4'd5:    r = 16'd2047;
			4'd6:    r = 16'd1024;
			4'd7:    r = 16'd512;
			4'd8:    r = 16'd256;
			4'd9:    r = 16'd128;
			4'd10:   r = 16'd64;
			4'd11:   r = 16'd32;
			4'd12:   r = 16'd16;
			4'd13:   r = 16'd8;
			4'd14:   r = 16'd4;
			default: r = 16'd2;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/swsk_if.sv
// ----------------------------------------------------------------------------
// swsk_if
// Valid/ready channels for velocity commands and wheel results.
// ----------------------------------------------------------------------------
interface swsk_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swsk_pkg::CMD_W-1:0]    linear_velocity;
	logic signed [swsk_pkg::CMD_W-1:0]    angular_velocity;

	modport source (output valid, output linear_velocity, output angular_velocity,
		input ready);
	modport sink (input valid, input linear_velocity, input angular_velocity,
		output ready);
endinterface

interface swsk_wheel_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [swsk_pkg::SPEED_W-1:0]  middle_left_speed;
	logic signed [swsk_pkg::SPEED_W-1:0]  middle_right_speed;
	logic signed [swsk_pkg::SPEED_W-1:0]  front_left_speed;
	logic signed [swsk_pkg::SPEED_W-1:0]  front_right_speed;
	logic signed [swsk_pkg::SPEED_W-1:0]  rear_left_speed;
	logic signed [swsk_pkg::SPEED_W-1:0]  rear_right_speed;
	logic signed [swsk_pkg::ANGLE_W-1:0]  front_right_angle;
	logic signed [swsk_pkg::ANGLE_W-1:0]  front_left_angle;
	logic signed [swsk_pkg::ANGLE_W-1:0]  rear_right_angle;
	logic signed [swsk_pkg::ANGLE_W-1:0]  rear_left_angle;

	modport source (output valid, output middle_left_speed, output middle_right_speed,
		output front_left_speed, output front_right_speed, output rear_left_speed,
		output rear_right_speed, output front_right_angle, output front_left_angle,
		output rear_right_angle, output rear_left_angle, input ready);
	modport sink (input valid, input middle_left_speed, input middle_right_speed,
		input front_left_speed, input front_right_speed, input rear_left_speed,
		input rear_right_speed, input front_right_angle, input front_left_angle,
		input rear_right_angle, input rear_left_angle, output ready);
endinterface

// File: hdl/swsk_isqrt.sv
// ----------------------------------------------------------------------------
// swsk_isqrt
// Bit-serial integer square root of a 64-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module swsk_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// one result bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// File: hdl/swsk_cordic.sv
// ----------------------------------------------------------------------------
// swsk_cordic
// Vectoring cordic atan2, sixteen steps, angle rounded to Q2.12.
// ----------------------------------------------------------------------------
module swsk_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [35:0]                   y_in,
	input  logic signed [35:0]                   x_in,
	output logic                                 done,
	output logic signed [swsk_pkg::ANGLE_W-1:0]  angle
);

	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [19:0] z_q;
	logic [3:0]         step_q;
	logic               busy_q;
	logic               done_q;
	logic signed [35:0] dx;
	logic signed [35:0] dy;
	logic signed [19:0] step_angle;
	logic [19:0]        z_mag;
	logic [15:0]        r_mag;
	logic [15:0]        r_neg;

	assign dx         = y_q >>> step_q;
	assign dy         = x_q >>> step_q;
	assign step_angle = $signed({4'b0, swsk_pkg::atan_entry(step_q)});

	// step counter and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// pre-rotation for the left half plane, then micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in < 0) begin
				x_q <= y_in;
				y_q <= -x_in;
				z_q <= swsk_pkg::HALF_PI_Q16;
			end else begin
				x_q <= x_in;
				y_q <= y_in;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_angle;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_angle;
			end
		end
	end

	// round half away from zero to Q2.12 and saturate
	always_comb begin
		z_mag = z_q[19] ? 20'(-z_q) : 20'(z_q);
		r_mag = 16'((z_mag + 20'd8) >> 4);
		r_neg = 16'(-r_mag);
		if (!z_q[19]) begin
			angle = (r_mag > 16'd16383) ? 15'sd16383 : $signed(r_mag[14:0]);
		end else begin
			angle = (r_mag > 16'd16384) ? -15'sd16384 : $signed(r_neg[14:0]);
		end
	end

	assign done = done_q;

endmodule

// File: hdl/swsk_dp.sv
// ----------------------------------------------------------------------------
// swsk_dp
// Datapath: command registers, geometry products, shared squarer, square root
// and cordic units, wheel speed scaling and the output register.
// ----------------------------------------------------------------------------
module swsk_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [swsk_pkg::CMD_W-1:0]  linear_velocity,
	input  logic signed [swsk_pkg::CMD_W-1:0]  angular_velocity,
	input  swsk_pkg::swsk_cmd_t                cmd,
	output swsk_pkg::swsk_status_t             status,
	swsk_wheel_if.source                       wheels
);

	logic signed [15:0] v_q;
	logic signed [15:0] w_q;
	logic signed [15:0] prev_lin_q;
	logic signed [15:0] prev_ang_q;
	logic [15:0]        v_mag;
	logic [15:0]        w_mag;
	logic [31:0]        a_q;
	logic [30:0]        d1w_q;
	logic [30:0]        d2w_q;
	logic [30:0]        d3w_q;
	logic [30:0]        d4w_q;
	logic signed [33:0] near_diff;
	logic [31:0]        near_mag;
	logic [31:0]        ha;
	logic [31:0]        hb;
	logic [31:0]        sq_op;
	logic [63:0]        sq;
	logic [63:0]        acc_q;
	logic [31:0]        root;
	logic               sqrt_done;
	logic [31:0]        h0_q;
	logic [31:0]        h1_q;
	logic signed [35:0] cor_y;
	logic signed [35:0] cor_x;
	logic signed [14:0] cor_angle;
	logic               cor_done;
	logic signed [14:0] t0_q;
	logic signed [14:0] t1_q;
	logic signed [33:0] sp_n [6];
	logic signed [14:0] an_n [4];
	logic signed [33:0] sp_q [6];
	logic signed [14:0] an_q [4];
	logic signed [33:0] conv_in;
	logic [33:0]        conv_mag;
	logic [36:0]        conv_n;
	logic [23:0]        conv_t_q;
	logic               conv_neg_q;
	logic [47:0]        conv_prod;
	logic [22:0]        conv_q;
	logic [22:0]        conv_qneg;
	logic signed [20:0] conv_res;
	logic signed [20:0] spd_q [6];
	logic               out_valid_q;
	logic signed [20:0] out_spd_q [6];
	logic signed [14:0] out_an_q [4];
	logic [1:0]         mode;

	// command capture and previous-command store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= linear_velocity;
			w_q <= angular_velocity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lin_q <= '0;
			prev_ang_q <= '0;
		end else if (cmd.prep) begin
			prev_lin_q <= v_q;
			prev_ang_q <= w_q;
		end
	end

	// mode decode
	always_comb begin
		if (v_q == 16'sd0 && w_q == 16'sd0) begin
			mode = swsk_pkg::MODE_STOP;
		end else if (w_q == 16'sd0) begin
			mode = swsk_pkg::MODE_STRAIGHT;
		end else if (v_q == 16'sd0) begin
			mode = swsk_pkg::MODE_ROTATE;
		end else begin
			mode = swsk_pkg::MODE_ARC;
		end
	end

	assign v_mag = v_q[15] ? 16'(-v_q) : 16'(v_q);
	assign w_mag = w_q[15] ? 16'(-w_q) : 16'(w_q);

	// geometry products in Q.28
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			a_q   <= {v_mag, 16'h0000};
			d1w_q <= 31'(swsk_pkg::GEO_D1) * 31'(w_mag);
			d2w_q <= 31'(swsk_pkg::GEO_D2) * 31'(w_mag);
			d3w_q <= 31'(swsk_pkg::GEO_D3) * 31'(w_mag);
			d4w_q <= 31'(swsk_pkg::GEO_D4) * 31'(w_mag);
		end
	end

	// hypot operands
	assign near_diff = $signed({2'b00, a_q}) - $signed({3'b000, d1w_q});
	assign near_mag  = near_diff[33] ? 32'(-near_diff) : 32'(near_diff);

	always_comb begin
		case (cmd.sel)
			swsk_pkg::SEL_ARC_NEAR: ha = near_mag;
			swsk_pkg::SEL_ARC_FAR:  ha = a_q + {1'b0, d1w_q};
			default:                ha = {1'b0, d1w_q};
		endcase
		hb = (cmd.sel == swsk_pkg::SEL_ROT12) ? {1'b0, d2w_q} : {1'b0, d3w_q};
	end

	// shared squarer, sum of squares accumulated in the sq_first then sq_second steps
	assign sq_op = cmd.sq_second ? hb : ha;
	assign sq    = 64'(sq_op) * 64'(sq_op);

	always_ff @(posedge clk) begin
		if (cmd.sq_first) begin
			acc_q <= sq;
		end else if (cmd.sq_second) begin
			acc_q <= acc_q + sq;
		end
	end

	swsk_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (acc_q),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_store) begin
			if (cmd.sel[0]) begin
				h1_q <= root;
			end else begin
				h0_q <= root;
			end
		end
	end

	// atan2 operands
	always_comb begin
		case (cmd.sel)
			swsk_pkg::SEL_ROT13: begin
				cor_y = $signed(36'({swsk_pkg::GEO_D3, 12'h000}));
				cor_x = $signed(36'({swsk_pkg::GEO_D1, 12'h000}));
			end
			swsk_pkg::SEL_ROT12: begin
				cor_y = $signed(36'({swsk_pkg::GEO_D2, 12'h000}));
				cor_x = $signed(36'({swsk_pkg::GEO_D1, 12'h000}));
			end
			default: begin
				cor_y = $signed(36'(d3w_q));
				cor_x = 36'(near_diff);
			end
		endcase
	end

	swsk_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.cor_start),
		.y_in   (cor_y),
		.x_in   (cor_x),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	always_ff @(posedge clk) begin
		if (cmd.cor_store) begin
			if (cmd.sel == swsk_pkg::SEL_ROT12) begin
				t1_q <= cor_angle;
			end else begin
				t0_q <= cor_angle;
			end
		end
	end

	// per-wheel linear speeds and angles for each mode
	always_comb begin
		logic signed [33:0] vlin;
		logic signed [33:0] d4s;
		logic signed [33:0] h0s;
		logic signed [33:0] h1s;
		logic signed [33:0] aps;
		logic signed [33:0] mc;
		logic signed [33:0] mf;
		logic signed [33:0] cc;
		logic signed [33:0] cf;
		logic               left;
		vlin = $signed({{2{v_q[15]}}, v_q, 16'h0000});
		d4s  = $signed({3'b000, d4w_q});
		h0s  = $signed({2'b00, h0_q});
		h1s  = $signed({2'b00, h1_q});
		aps  = $signed({2'b00, a_q});
		mc   = v_q[15] ? d4s - aps : aps - d4s;
		mf   = v_q[15] ? -(aps + d4s) : aps + d4s;
		cc   = v_q[15] ? -h0s : h0s;
		cf   = v_q[15] ? -h1s : h1s;
		left = (v_q > 0) == (w_q > 0);
		for (int k = 0; k < 6; k++) begin
			sp_n[k] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			an_n[k] = '0;
		end
		case (mode)
			swsk_pkg::MODE_STRAIGHT: begin
				for (int k = 0; k < 6; k++) begin
					sp_n[k] = vlin;
				end
			end
			swsk_pkg::MODE_ROTATE: begin
				// the sign of w sets the direction of each wheel speed magnitude
				sp_n[0] = w_q[15] ? d4s : -d4s;
				sp_n[1] = w_q[15] ? -h1s : h1s;
				sp_n[2] = w_q[15] ? h0s : -h0s;
				sp_n[3] = w_q[15] ? -h0s : h0s;
				sp_n[4] = w_q[15] ? h1s : -h1s;
				sp_n[5] = w_q[15] ? -d4s : d4s;
				an_n[0] = t0_q;
				an_n[1] = 15'(-t0_q);
				an_n[2] = 15'(-t1_q);
				an_n[3] = t1_q;
			end
			swsk_pkg::MODE_ARC: begin
				if (left) begin
					sp_n[0] = mc; sp_n[1] = mf; sp_n[2] = cc;
					sp_n[3] = cf; sp_n[4] = cc; sp_n[5] = cf;
					an_n[0] = t0_q;
					an_n[1] = t0_q;
					an_n[2] = 15'(-t0_q);
					an_n[3] = 15'(-t0_q);
				end else begin
					sp_n[0] = mf; sp_n[1] = mc; sp_n[2] = cf;
					sp_n[3] = cc; sp_n[4] = cf; sp_n[5] = cc;
					an_n[0] = 15'(-t0_q);
					an_n[1] = 15'(-t0_q);
					an_n[2] = t0_q;
					an_n[3] = t0_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.assign_out) begin
			sp_q <= sp_n;
			an_q <= an_n;
		end
	end

	// speed scaling: round(x * 5 / 24576), shift by 8192 then divide by 3
	assign conv_in  = sp_q[cmd.idx];
	assign conv_mag = conv_in[33] ? 34'(-conv_in) : 34'(conv_in);
	assign conv_n   = 37'(conv_mag) * 37'd5 + 37'd12288;

	always_ff @(posedge clk) begin
		if (cmd.conv_first) begin
			conv_t_q   <= conv_n[36:13];
			conv_neg_q <= conv_in[33];
		end
	end

	assign conv_prod = 48'(conv_t_q) * 48'hAA_AAAB;
	assign conv_q    = conv_prod[47:25];
	assign conv_qneg = 23'(-conv_q);

	always_comb begin
		if (conv_neg_q) begin
			conv_res = (conv_q > 23'd1048576) ? -21'sd1048576 : $signed(conv_qneg[20:0]);
		end else begin
			conv_res = (conv_q > 23'd1048575) ? 21'sd1048575 : $signed(conv_q[20:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.conv_second) begin
			spd_q[cmd.idx] <= conv_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (wheels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_spd_q <= spd_q;
			out_an_q  <= an_q;
		end
	end

	assign wheels.valid              = out_valid_q;
	assign wheels.middle_left_speed  = out_spd_q[0];
	assign wheels.middle_right_speed = out_spd_q[1];
	assign wheels.front_left_speed   = out_spd_q[2];
	assign wheels.front_right_speed  = out_spd_q[3];
	assign wheels.rear_left_speed    = out_spd_q[4];
	assign wheels.rear_right_speed   = out_spd_q[5];
	assign wheels.front_right_angle  = out_an_q[0];
	assign wheels.front_left_angle   = out_an_q[1];
	assign wheels.rear_right_angle   = out_an_q[2];
	assign wheels.rear_left_angle    = out_an_q[3];

	// status back to the controller
	assign status.repeated  = (v_q == prev_lin_q) && (w_q == prev_ang_q);
	assign status.mode      = mode;
	assign status.sqrt_done = sqrt_done;
	assign status.cor_done  = cor_done;
	assign status.out_free  = !out_valid_q || wheels.ready;

endmodule

// File: hdl/swsk_ctrl.sv
// ----------------------------------------------------------------------------
// swsk_ctrl
// Controller: sequences the hypot, atan2 and speed scaling jobs per command.
// ----------------------------------------------------------------------------
module swsk_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  swsk_pkg::swsk_status_t  status,
	output swsk_pkg::swsk_cmd_t     cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CHECK     = 4'd1;
	localparam logic [3:0] S_SQ1       = 4'd2;
	localparam logic [3:0] S_SQ2       = 4'd3;
	localparam logic [3:0] S_SQRT_GO   = 4'd4;
	localparam logic [3:0] S_SQRT_WAIT = 4'd5;
	localparam logic [3:0] S_COR_GO    = 4'd6;
	localparam logic [3:0] S_COR_WAIT  = 4'd7;
	localparam logic [3:0] S_ASSIGN    = 4'd8;
	localparam logic [3:0] S_CONV1     = 4'd9;
	localparam logic [3:0] S_CONV2     = 4'd10;
	localparam logic [3:0] S_OUT       = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic [1:0] sel_q;
	logic [1:0] sel_n;
	logic [2:0] idx_q;
	logic [2:0] idx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= swsk_pkg::SEL_ROT13;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
			idx_q   <= idx_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n  = state_q;
		sel_n    = sel_q;
		idx_n    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.idx  = idx_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.repeated) begin
					state_n = S_IDLE;
				end else begin
					cmd.prep = 1'b1;
					case (status.mode)
						swsk_pkg::MODE_ROTATE: begin
							sel_n   = swsk_pkg::SEL_ROT13;
							state_n = S_SQ1;
						end
						swsk_pkg::MODE_ARC: begin
							sel_n   = swsk_pkg::SEL_ARC_NEAR;
							state_n = S_SQ1;
						end
						default: state_n = S_ASSIGN;
					endcase
				end
			end
			S_SQ1: begin
				cmd.sq_first = 1'b1;
				state_n      = S_SQ2;
			end
			S_SQ2: begin
				cmd.sq_second = 1'b1;
				state_n       = S_SQRT_GO;
			end
			S_SQRT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_n        = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (status.sqrt_done) begin
					cmd.sqrt_store = 1'b1;
					case (sel_q)
						swsk_pkg::SEL_ROT13: begin
							sel_n   = swsk_pkg::SEL_ROT12;
							state_n = S_SQ1;
						end
						swsk_pkg::SEL_ROT12: begin
							sel_n   = swsk_pkg::SEL_ROT13;
							state_n = S_COR_GO;
						end
						swsk_pkg::SEL_ARC_NEAR: begin
							sel_n   = swsk_pkg::SEL_ARC_FAR;
							state_n = S_SQ1;
						end
						default: begin
							sel_n   = swsk_pkg::SEL_ARC_NEAR;
							state_n = S_COR_GO;
						end
					endcase
				end
			end
			S_COR_GO: begin
				cmd.cor_start = 1'b1;
				state_n       = S_COR_WAIT;
			end
			S_COR_WAIT: begin
				if (status.cor_done) begin
					cmd.cor_store = 1'b1;
					if (sel_q == swsk_pkg::SEL_ROT13) begin
						sel_n   = swsk_pkg::SEL_ROT12;
						state_n = S_COR_GO;
					end else begin
						state_n = S_ASSIGN;
					end
				end
			end
			S_ASSIGN: begin
				cmd.assign_out = 1'b1;
				idx_n          = '0;
				state_n        = S_CONV1;
			end
			S_CONV1: begin
				cmd.conv_first = 1'b1;
				state_n        = S_CONV2;
			end
			S_CONV2: begin
				cmd.conv_second = 1'b1;
				if (idx_q == swsk_pkg::LAST_WHEEL) begin
					state_n = S_OUT;
				end else begin
					idx_n   = idx_q + 3'd1;
					state_n = S_CONV1;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

endmodule

// File: hdl/six_wheel_steering_kinematics.sv
// ----------------------------------------------------------------------------
// six_wheel_steering_kinematics
// Inverse kinematics for a six-wheel rover with four steered corners.
//
//   port     role    payload
//   command  sink    linear_velocity, angular_velocity (Q3.12)
//   wheels   source  six wheel speeds (Q8.12), four steering angles (Q2.12)
//
// One command at a time. A repeated command gives nothing. For an arc turn or
// a rotation the 32-step square root runs twice and the 16-step cordic once
// (arc) or twice (rotate); stop and straight skip both. Six speed scalings then
// follow, each in a conv_first and then a conv_second step.
// A finished result sits in the output register while the next command is
// taken; the controller stalls before loading a new result until it drains.
// Reset clears the stored previous command to zero and empties the output.
// ----------------------------------------------------------------------------
module six_wheel_steering_kinematics (
	input  logic          clk,
	input  logic          arst_n,
	swsk_cmd_if.sink      command,
	swsk_wheel_if.source  wheels
);

	swsk_pkg::swsk_cmd_t    cmd;
	swsk_pkg::swsk_status_t status;
	logic                   ready;

	assign command.ready = ready;

	swsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (command.valid),
		.in_ready (ready),
		.status   (status),
		.cmd      (cmd)
	);

	swsk_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.linear_velocity  (command.linear_velocity),
		.angular_velocity (command.angular_velocity),
		.cmd              (cmd),
		.status           (status),
		.wheels           (wheels)
	);

endmodule

// File: sim/tb_six_wheel_steering_kinematics.sv
// ----------------------------------------------------------------------------
// tb_six_wheel_steering_kinematics
// Self-checking bench for the six-wheel steering kinematics block. A directed
// table covers reset, extremes and every drive mode, then random velocity
// commands follow. Each command is run through a bit-exact predictor, and each
// wheel transaction is checked field by field against the oldest prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_six_wheel_steering_kinematics;

	typedef struct packed {
		logic signed [swsk_pkg::SPEED_W-1:0] ml, mr, fl, fr, rl, rr;
		logic signed [swsk_pkg::ANGLE_W-1:0] afr, afl, arr, arl;
	} wheel_set_t;

	typedef struct {
		logic signed [15:0] lin, ang;
		bit                 known;
		wheel_set_t         want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	swsk_cmd_if   cmd_ch ();
	swsk_wheel_if whl_ch ();

	six_wheel_steering_kinematics u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.command (cmd_ch.sink),
		.wheels  (whl_ch.source)
	);

	wheel_set_t         pending_wheels[$];
	logic signed [15:0] last_lin, last_ang;
	int                 error_count = 0;
	longint             cycle_count = 0;
	bit                 sink_busy = 1'b0;

	localparam longint CYCLE_LIMIT = 3000000;

	// helpers in 64-bit integer arithmetic
	function automatic longint floor_shr(longint a, int s);
		return a >>> s;
	endfunction

	function automatic longint rdiv(longint v, longint d);
		longint m, q;
		m = v < 0 ? -v : v;
		q = (m + d / 2) / d;
		return v < 0 ? -q : q;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint hyp64(longint a, longint b);
		if (a < 0) a = -a;
		if (b < 0) b = -b;
		return root_floor(a * a + b * b);
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, t, dx, dy;
		z = 0;
		if (x < 0) begin
			t = x; x = y; y = -t; z = swsk_pkg::HALF_PI_Q16;
		end
		for (int i = 0; i < 16; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(swsk_pkg::atan_entry(i[3:0]));
			end else begin
				x -= dx; y += dy; z -= longint'(swsk_pkg::atan_entry(i[3:0]));
			end
		end
		return clamp(rdiv(z, 16), -16384, 16383);
	endfunction

	function automatic logic signed [swsk_pkg::SPEED_W-1:0] wheel_rate(longint q28);
		longint t;
		t = clamp(rdiv(q28 * 40, 196608), -1048576, 1048575);
		return t[swsk_pkg::SPEED_W-1:0];
	endfunction

	function automatic logic signed [swsk_pkg::ANGLE_W-1:0] angle_field(longint a);
		longint t;
		t = clamp(a, -16384, 16383);
		return t[swsk_pkg::ANGLE_W-1:0];
	endfunction

	// returns 1 when the command yields a wheel transaction
	function automatic bit solve_kinematics(logic signed [15:0] lin,
			logic signed [15:0] ang, output wheel_set_t res);
		longint v, w, sp[6], an[4], sg, h13, h12, t13, t12;
		longint s, a, wm, mc, mf, cc, cf, th;
		longint d1, d2, d3, d4;
		v = lin; w = ang;
		d1 = swsk_pkg::GEO_D1; d2 = swsk_pkg::GEO_D2;
		d3 = swsk_pkg::GEO_D3; d4 = swsk_pkg::GEO_D4;
		res = '0;
		for (int k = 0; k < 6; k++) sp[k] = 0;
		for (int k = 0; k < 4; k++) an[k] = 0;
		if (lin == last_lin && ang == last_ang) return 1'b0;
		last_lin = lin;
		last_ang = ang;
		if (w == 0 && v != 0) begin
			for (int k = 0; k < 6; k++) sp[k] = v * 65536;
		end else if (w != 0 && v == 0) begin
			sg = w < 0 ? -1 : 1;
			h13 = sg * hyp64(d1 * w, d3 * w);
			h12 = sg * hyp64(d1 * w, d2 * w);
			t13 = vector_angle(d3 * 4096, d1 * 4096);
			t12 = vector_angle(d2 * 4096, d1 * 4096);
			sp[0] = -d4 * w; sp[1] = h12; sp[2] = -h13;
			sp[3] = h13; sp[4] = -h12; sp[5] = d4 * w;
			an[0] = t13; an[1] = -t13; an[2] = -t12; an[3] = t12;
		end else if (w != 0 && v != 0) begin
			s = v < 0 ? -1 : 1;
			a = (v < 0 ? -v : v) * 65536;
			wm = w < 0 ? -w : w;
			mc = s * (a - d4 * wm);
			mf = s * (a + d4 * wm);
			cc = s * hyp64(a - d1 * wm, d3 * wm);
			cf = s * hyp64(a + d1 * wm, d3 * wm);
			th = vector_angle(d3 * wm, a - d1 * wm);
			if ((v > 0) == (w > 0)) begin
				sp[0] = mc; sp[1] = mf; sp[2] = cc; sp[3] = cf; sp[4] = cc; sp[5] = cf;
				an[0] = th; an[1] = th; an[2] = -th; an[3] = -th;
			end else begin
				sp[0] = mf; sp[1] = mc; sp[2] = cf; sp[3] = cc; sp[4] = cf; sp[5] = cc;
				an[0] = -th; an[1] = -th; an[2] = th; an[3] = th;
			end
		end
		res.ml = wheel_rate(sp[0]); res.mr = wheel_rate(sp[1]);
		res.fl = wheel_rate(sp[2]); res.fr = wheel_rate(sp[3]);
		res.rl = wheel_rate(sp[4]); res.rr = wheel_rate(sp[5]);
		res.afr = angle_field(an[0]);
		res.afl = angle_field(an[1]);
		res.arr = angle_field(an[2]);
		res.arl = angle_field(an[3]);
		return 1'b1;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// entered and left at a falling edge; valid stays up only for back-to-back
	task automatic send_command(logic signed [15:0] lin, logic signed [15:0] ang,
			bit known, wheel_set_t typed);
		wheel_set_t res;
		bit         yields;
		int         gap;
		gap = idle_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid            <= 1'b1;
		cmd_ch.linear_velocity  <= lin;
		cmd_ch.angular_velocity <= ang;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		yields = solve_kinematics(lin, ang, res);
		if (known && yields && res != typed) begin
			$display("%0t table row disagrees with predictor: expected %h actual %h",
				$time, typed, res);
			error_count++;
		end
		if (yields) pending_wheels.insert(pending_wheels.size(), known ? typed : res);
		@(negedge clk);
	endtask

	// result checking
	always @(posedge clk) begin
		wheel_set_t got, exp_w;
		if (arst_n && whl_ch.valid && whl_ch.ready) begin
			got = {whl_ch.middle_left_speed, whl_ch.middle_right_speed,
				whl_ch.front_left_speed, whl_ch.front_right_speed,
				whl_ch.rear_left_speed, whl_ch.rear_right_speed,
				whl_ch.front_right_angle, whl_ch.front_left_angle,
				whl_ch.rear_right_angle, whl_ch.rear_left_angle};
			if (pending_wheels.size() == 0) begin
				$display("%0t unexpected wheel transaction: expected none, actual %h",
					$time, got);
				error_count++;
			end else begin
				exp_w = pending_wheels.pop_front();
				if (got.ml != exp_w.ml || got.mr != exp_w.mr || got.fl != exp_w.fl ||
						got.fr != exp_w.fr || got.rl != exp_w.rl || got.rr != exp_w.rr ||
						got.afr != exp_w.afr || got.afl != exp_w.afl ||
						got.arr != exp_w.arr || got.arl != exp_w.arl) begin
					$display("%0t wheel mismatch: expected %p actual %p", $time, exp_w, got);
					error_count++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		int g;
		if (!sink_busy) begin
			sink_busy = 1'b1;
			whl_ch.ready <= 1'b1;
			g = idle_gap();
			if (g > 0) begin
				@(negedge clk);
				whl_ch.ready <= 1'b0;
				repeat (g - 1) @(negedge clk);
			end
			sink_busy = 1'b0;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_six_wheel_steering_kinematics: done, errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_field();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sd0;
		if (r == 1) return 16'sh7fff;
		if (r == 2) return 16'sh8000;
		if (r < 6) return 16'($signed($urandom_range(0, 16383)) - 8192);
		return 16'($urandom);
	endfunction

	initial begin
		stim_row_t          rows[$];
		logic signed [15:0] rl, ra;
		int                 r, idle_wait;
		wheel_set_t         zero_set;
		zero_set = '0;
		last_lin = 0;
		last_ang = 0;
		cmd_ch.valid = 1'b0;
		cmd_ch.linear_velocity = '0;
		cmd_ch.angular_velocity = '0;
		whl_ch.ready = 1'b0;

		// directed table: first row is the stop repeat after reset
		rows.insert(rows.size(), '{16'sd0, 16'sd0, 1'b1, zero_set});
		rows.insert(rows.size(), '{16'sd4096, 16'sd0, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd4096, 16'sd0, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, 16'sd0, 1'b1, zero_set});
		rows.insert(rows.size(), '{16'sh7fff, 16'sd0, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sh8000, 16'sd0, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, 16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, -16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, 16'sh7fff, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, 16'sh8000, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd4096, 16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{-16'sd4096, -16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd4096, -16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{-16'sd4096, 16'sd4096, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd100, 16'sd20000, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sh7fff, 16'sh7fff, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sh8000, 16'sh8000, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sh7fff, 16'sh8000, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sh8000, 16'sh7fff, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd1, 16'sd1, 1'b0, zero_set});
		rows.insert(rows.size(), '{-16'sd1, 16'sd1, 1'b0, zero_set});
		rows.insert(rows.size(), '{16'sd0, 16'sd0, 1'b1, zero_set});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_command(rows[i].lin, rows[i].ang, rows[i].known, rows[i].want);

		// hold off until every pending result has drained
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_wheels.size() != 0) @(negedge clk);

		for (int n = 0; n < 900; n++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				rl = last_lin; ra = last_ang;
			end else if (r < 16) begin
				rl = pick_field(); ra = 16'sd0;
			end else if (r < 24) begin
				rl = 16'sd0; ra = pick_field();
			end else if (r < 28) begin
				rl = 16'sd0; ra = 16'sd0;
			end else begin
				rl = pick_field(); ra = pick_field();
			end
			send_command(rl, ra, 1'b0, zero_set);
			if (n == 450) begin
				cmd_ch.valid <= 1'b0;
				@(negedge clk);
				while (pending_wheels.size() != 0) @(negedge clk);
			end
		end

		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_wheels.size() != 0) @(negedge clk);
		idle_wait = 400;
		repeat (idle_wait) @(negedge clk);
		if (error_count == 0 && pending_wheels.size() == 0) begin
			$display("tb_six_wheel_steering_kinematics: done, clean");
		end else begin
			$display("tb_six_wheel_steering_kinematics: done, errors");
		end
		$finish;
	end
endmodule
